// ===== rtl/tdtq_pkg.sv =====
// Shared types, constants and helpers of the sorted deadline timer queue.
package tdtq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int TIME_BITS  = 32;
  localparam int ID_W       = 4;
  localparam int DUR_W      = 32;
  localparam int MAX_OUT    = 16;
  localparam int CNT_W      = $clog2(MAX_OUT + 1);
  localparam int IN_W       = 40;
  localparam int OUT_W      = 8;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ID_W-1:0]      tid_t;

  typedef enum logic [1:0] {
    OP_ARM_ONESHOT  = 2'd0,
    OP_ARM_PERIODIC = 2'd1,
    OP_CANCEL       = 2'd2,
    OP_TICK         = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_REMOVE,
    CMD_POP,
    CMD_INSERT
  } cmd_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM_INS,
    ST_POP,
    ST_REARM,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic  valid;
    tid_t  id;
    time_t dl;
    time_t per;
  } entry_t;

  typedef struct packed {
    cmd_op_t op;
    tid_t    id;
    time_t   dl;
    time_t   per;
  } chain_cmd_t;

  localparam entry_t EMPTY_ENT = '0;

  // True when a lies strictly after b on the wrapping time line.
  function automatic logic is_after(time_t a, time_t b);
    time_t d;
    d = a - b;
    return (d != '0) && !d[TIME_BITS-1];
  endfunction

endpackage

// ===== rtl/tdtq_cell.sv =====
// One cell of the sorted timer chain: holds a single queue entry.
module tdtq_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  tdtq_pkg::chain_cmd_t   cmd,
  input  tdtq_pkg::entry_t       prev_ent,
  input  tdtq_pkg::entry_t       next_ent,
  input  logic                   rm_in,
  input  logic                   ins_in,
  output tdtq_pkg::entry_t       ent,
  output logic                   rm_out,
  output logic                   ins_out
);
  import tdtq_pkg::*;

  entry_t ent_next;
  logic   hit_rm;
  logic   hit_ins;

  always_comb begin
    hit_rm  = (cmd.op == CMD_REMOVE) && ent.valid && (ent.id == cmd.id);
    rm_out  = rm_in | hit_rm;
    // The first empty cell or the first later deadline takes the new entry.
    hit_ins = !ent.valid || is_after(ent.dl, cmd.dl);
    ins_out = ins_in | hit_ins;
    ent_next = ent;
    case (cmd.op)
      CMD_REMOVE, CMD_POP: begin
        if (rm_out) ent_next = next_ent;
      end
      CMD_INSERT: begin
        if (ins_in) begin
          ent_next = prev_ent;
        end else if (hit_ins) begin
          ent_next.valid = 1'b1;
          ent_next.id    = cmd.id;
          ent_next.dl    = cmd.dl;
          ent_next.per   = cmd.per;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

// ===== rtl/tdtq_chain.sv =====
// Row of timer cells kept sorted by deadline, head at cell zero.
module tdtq_chain (
  input  logic                 clk,
  input  logic                 rst,
  input  tdtq_pkg::chain_cmd_t cmd,
  output tdtq_pkg::entry_t     head,
  output logic                 full
);
  import tdtq_pkg::*;

  entry_t ents [NUM_TIMERS];
  logic   rm_c  [NUM_TIMERS+1];
  logic   ins_c [NUM_TIMERS+1];

  // A pop shifts the whole row; a removal shifts from the matching cell on.
  assign rm_c[0]  = (cmd.op == CMD_POP);
  assign ins_c[0] = 1'b0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    if (i == 0) begin : g_first
      assign prev_e = EMPTY_ENT;
    end else begin : g_mid
      assign prev_e = ents[i-1];
    end
    if (i == NUM_TIMERS - 1) begin : g_last
      assign next_e = EMPTY_ENT;
    end else begin : g_inner
      assign next_e = ents[i+1];
    end
    tdtq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .prev_ent (prev_e),
      .next_ent (next_e),
      .rm_in    (rm_c[i]),
      .ins_in   (ins_c[i]),
      .ent      (ents[i]),
      .rm_out   (rm_c[i+1]),
      .ins_out  (ins_c[i+1])
    );
  end

  assign head = ents[0];
  assign full = ents[NUM_TIMERS-1].valid;

endmodule

// ===== rtl/sorted_deadline_timer_queue.sv =====
// Top level of the sorted deadline timer queue: request decode, tick sequencer, result stage.
//
// This block keeps up to sixteen timers in a chain of cells sorted by deadline,
// nearest first, with timers of equal deadline kept in the order they were armed.
// Each request carries an op: arm one-shot, arm periodic, cancel, or tick. Arming
// sets the deadline to the current time plus the duration and replaces any entry
// the timer already had; a periodic timer keeps the duration as its period, and a
// period of zero makes it a one-shot timer. Arming a new timer while all cells are
// busy is dropped. A tick advances the time by one and then pops every timer at the
// head whose deadline is not after the new time, using a wrapping signed compare;
// each popped timer id leaves on the result channel, and the final one of the tick
// carries tlast. A timer expires at most once per tick and a tick yields at most
// sixteen results; whatever remains due stays queued for the next tick. A tick that
// finds nothing due yields no result. Requests are taken one at a time: a cancel
// is a single removal, an arm is a removal and then an insert into the chain, and a
// tick runs the accept, one pop per expired timer with a sorted re-insert after each
// periodic one, the check that finds the head not due, and the final result hand-off.
// Each chain operation (a removal, a pop or a sorted insert) occupies the whole row of
// cells. A stall on the result channel holds the tick back.
// After reset the queue is empty and the time is zero.
module sorted_deadline_timer_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // Fields from bit 0 up: op[1:0], timer_id[5:2], duration[37:6], zero pad.
  input  logic [tdtq_pkg::IN_W-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // Fields from bit 0 up: expired_timer_id[3:0], zero pad.
  output logic [tdtq_pkg::OUT_W-1:0]   m_tdata,
  output logic                         m_tlast
);
  import tdtq_pkg::*;

  // Request fields.
  op_t               in_op;
  tid_t              in_id;
  logic [DUR_W-1:0]  in_dur;
  logic              id_ok;

  assign in_op  = op_t'(s_tdata[1:0]);
  assign in_id  = s_tdata[ID_W+1:2];
  assign in_dur = s_tdata[DUR_W+ID_W+1:ID_W+2];
  assign id_ok  = (32'(in_id) < NUM_TIMERS);

  // Sequencer state and working registers.
  state_t                  state, state_next;
  time_t                   now, now_next;
  tid_t                    ins_id, ins_id_next;
  time_t                   ins_dl, ins_dl_next;
  time_t                   ins_per, ins_per_next;
  logic [NUM_TIMERS-1:0]   popped, popped_next;
  logic [CNT_W-1:0]        n_out, n_out_next;

  // The newest popped id waits here until we know whether it is the last one.
  logic pend_valid, pend_valid_next;
  tid_t pend_id, pend_id_next;

  // Output register.
  logic out_valid, out_valid_next;
  tid_t out_id, out_id_next;
  logic out_last, out_last_next;

  chain_cmd_t cmd;
  entry_t     head;
  logic       full;
  logic       out_free;
  logic       due;

  tdtq_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .head (head),
    .full (full)
  );

  assign out_free = !out_valid || m_tready;

  // The head expires when it is due now, has not already fired this tick, and the tick is under its result cap.
  assign due = head.valid && !popped[head.id] && (n_out < CNT_W'(MAX_OUT)) &&
               !is_after(head.dl, now);

  always_comb begin
    state_next      = state;
    now_next        = now;
    ins_id_next     = ins_id;
    ins_dl_next     = ins_dl;
    ins_per_next    = ins_per;
    popped_next     = popped;
    n_out_next      = n_out;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    out_valid_next  = out_valid;
    out_id_next     = out_id;
    out_last_next   = out_last;
    cmd.op  = CMD_NOP;
    cmd.id  = ins_id;
    cmd.dl  = ins_dl;
    cmd.per = ins_per;
    s_tready = (state == ST_IDLE);

    if (out_valid && m_tready) out_valid_next = 1'b0;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (in_op)
            OP_ARM_ONESHOT, OP_ARM_PERIODIC: begin
              if (id_ok) begin
                // Drop any old entry first; the insert follows next cycle.
                cmd.op       = CMD_REMOVE;
                cmd.id       = in_id;
                ins_id_next  = in_id;
                ins_dl_next  = now + TIME_BITS'(in_dur);
                ins_per_next = (in_op == OP_ARM_PERIODIC) ? TIME_BITS'(in_dur) : '0;
                state_next   = ST_ARM_INS;
              end
            end
            OP_CANCEL: begin
              if (id_ok) begin
                cmd.op = CMD_REMOVE;
                cmd.id = in_id;
              end
            end
            OP_TICK: begin
              now_next    = now + 1'b1;
              popped_next = '0;
              n_out_next  = '0;
              state_next  = ST_POP;
            end
            default: ;
          endcase
        end
      end

      ST_ARM_INS: begin
        if (!full) cmd.op = CMD_INSERT;
        state_next = ST_IDLE;
      end

      ST_POP: begin
        if (due) begin
          if (!pend_valid || out_free) begin
            cmd.op                = CMD_POP;
            popped_next[head.id]  = 1'b1;
            n_out_next            = n_out + 1'b1;
            pend_valid_next       = 1'b1;
            pend_id_next          = head.id;
            if (pend_valid) begin
              out_valid_next = 1'b1;
              out_id_next    = pend_id;
              out_last_next  = 1'b0;
            end
            if (head.per != '0) begin
              ins_id_next  = head.id;
              ins_dl_next  = now + head.per;
              ins_per_next = head.per;
              state_next   = ST_REARM;
            end
          end
        end else begin
          state_next = ST_FLUSH;
        end
      end

      ST_REARM: begin
        cmd.op     = CMD_INSERT;
        state_next = ST_POP;
      end

      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_id_next     = pend_id;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      now        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      now        <= now_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ins_id   <= ins_id_next;
    ins_dl   <= ins_dl_next;
    ins_per  <= ins_per_next;
    popped   <= popped_next;
    n_out    <= n_out_next;
    pend_id  <= pend_id_next;
    out_id   <= out_id_next;
    out_last <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_id);
  assign m_tlast  = out_last;

endmodule

// ===== dv/tb_sorted_deadline_timer_queue.sv =====
// Self-checking testbench for the sorted deadline timer queue, with a request driver and result monitor.
`timescale 1ns / 100ps

module tb_sorted_deadline_timer_queue;
  import tdtq_pkg::*;

  // One request as the driver offers it. A request marked wait_idle is held back
  // until every expiry predicted so far has been collected.
  typedef struct {
    op_t         op;
    tid_t        id;
    logic [31:0] dur;
    bit          wait_idle;
  } timer_req_t;

  // One expected expiry result.
  typedef struct {
    tid_t id;
    logic last;
  } expiry_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  // Fields from bit 0 up: op[1:0], timer_id[5:2], duration[37:6], zero pad.
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // Fields from bit 0 up: expired_timer_id[3:0], zero pad.
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  sorted_deadline_timer_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // Requests waiting to be driven, and expiries predicted but not yet seen.
  timer_req_t req_queue[$];
  expiry_t    expiry_q[$];
  timer_req_t in_flight;
  int         total_reqs = 0;
  int         accepted_reqs = 0;
  int         results_seen = 0;
  int         mismatches = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  logic [31:0] cyc = '0;
  logic       quiet;

  // Shadow state of the timer queue.
  logic [31:0] now_ticks = '0;
  tid_t        chain[NUM_TIMERS];
  int          chain_len = 0;
  logic [31:0] due_at[NUM_TIMERS];
  logic [31:0] period_of[NUM_TIMERS];
  bit          armed[NUM_TIMERS];

  // In the first quarter of every window of cyc (cyc[7:6] zero) the driver draws no gaps and the monitor no stalls.
  assign quiet = (cyc[7:6] == 2'b00);

  // True when deadline a lies strictly later than b on the wrapping time line.
  function automatic bit later_than(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != '0) && !d[31];
  endfunction

  // Take a timer out of the sorted chain and mark it idle.
  function automatic void drop_timer(tid_t id);
    int pos;
    pos = -1;
    for (int i = 0; i < chain_len; i++)
      if (pos < 0 && chain[i] == id) pos = i;
    if (pos >= 0) begin
      for (int j = pos; j < chain_len - 1; j++) chain[j] = chain[j + 1];
      chain_len--;
    end
    armed[id] = 1'b0;
  endfunction

  // Insert a timer behind every entry whose deadline is not later than its own,
  // so that equal deadlines stay in arming order. An armed timer is replaced.
  function automatic void arm_timer(tid_t id, logic [31:0] timeout, logic [31:0] period);
    int slot;
    bit found;
    if (armed[id]) drop_timer(id);
    due_at[id] = now_ticks + timeout;
    period_of[id] = period;
    if (chain_len >= NUM_TIMERS) return;
    slot = chain_len;
    found = 1'b0;
    for (int j = 0; j < chain_len; j++)
      if (!found && later_than(due_at[chain[j]], due_at[id])) begin
        slot = j;
        found = 1'b1;
      end
    for (int j = chain_len; j > slot; j--) chain[j] = chain[j - 1];
    chain[slot] = id;
    chain_len++;
    armed[id] = 1'b1;
  endfunction

  // Advance the shadow state by one accepted request and queue the expiries it causes.
  function automatic void apply_request(timer_req_t r);
    bit      fired[NUM_TIMERS];
    tid_t    fired_ids[MAX_OUT];
    tid_t    head;
    int      n;
    bit      stop;
    expiry_t e;
    case (r.op)
      OP_ARM_ONESHOT:  arm_timer(r.id, r.dur, '0);
      OP_ARM_PERIODIC: arm_timer(r.id, r.dur, r.dur);
      OP_CANCEL:       if (armed[r.id]) drop_timer(r.id);
      default: begin
        now_ticks = now_ticks + 1;
        for (int i = 0; i < NUM_TIMERS; i++) fired[i] = 1'b0;
        n = 0;
        stop = 1'b0;
        // A timer fires at most once per tick, so a periodic timer that lands
        // due again right away ends the tick instead of looping.
        while (!stop && chain_len > 0 && n < MAX_OUT) begin
          head = chain[0];
          if (fired[head] || later_than(due_at[head], now_ticks)) begin
            stop = 1'b1;
          end else begin
            drop_timer(head);
            fired[head] = 1'b1;
            fired_ids[n] = head;
            n++;
            if (period_of[head] != '0) arm_timer(head, period_of[head], period_of[head]);
          end
        end
        for (int k = 0; k < n; k++) begin
          e.id = fired_ids[k];
          e.last = (k == n - 1);
          expiry_q.push_back(e);
        end
      end
    endcase
  endfunction

  function automatic void add_req(op_t op, tid_t id, logic [31:0] dur, bit wait_idle);
    timer_req_t r;
    r.op = op;
    r.id = id;
    r.dur = dur;
    r.wait_idle = wait_idle;
    req_queue.push_back(r);
  endfunction

  // Random request: mostly short durations so that timers keep expiring, with
  // some medium ones and some spanning all 32 bits.
  function automatic timer_req_t random_req();
    timer_req_t r;
    int pick;
    int dsel;
    pick = $urandom_range(0, 99);
    dsel = $urandom_range(0, 99);
    r.id = tid_t'($urandom_range(0, NUM_TIMERS - 1));
    if (dsel < 70) r.dur = $urandom_range(0, 8);
    else if (dsel < 85) r.dur = $urandom_range(0, 300);
    else r.dur = $urandom;
    if (pick < 35) r.op = OP_TICK;
    else if (pick < 60) r.op = OP_ARM_ONESHOT;
    else if (pick < 85) r.op = OP_ARM_PERIODIC;
    else r.op = OP_CANCEL;
    r.wait_idle = 1'b0;
    return r;
  endfunction

  // Request driver. Valid stays up until the request is taken; the data of the
  // next request replaces it in the same assignment when no gap is drawn.
  always @(posedge clk) begin : driver
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready === 1'b1) begin
        apply_request(in_flight);
        accepted_reqs++;
      end
      if (!(s_tvalid && s_tready !== 1'b1)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (req_queue.size() > 0 &&
                     !(req_queue[0].wait_idle && expiry_q.size() != 0)) begin
          in_flight = req_queue.pop_front();
          s_tdata <= {2'b00, in_flight.dur, in_flight.id, in_flight.op};
          s_tvalid <= 1'b1;
          gap_left <= quiet ? 0 : $urandom_range(0, 3);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off: once a few dozen results are through, the result side
  // is held off once, on a counter, while the driver keeps offering, so the block backs up.
  always @(posedge clk) begin : hold_off
    cyc <= cyc + 1;
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && results_seen >= 30) begin
      hold_left <= 150;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: checks each accepted expiry against the oldest prediction.
  always @(posedge clk) begin : monitor
    expiry_t want;
    int      stall;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid === 1'b1 && m_tready) begin
        results_seen <= results_seen + 1;
        if (expiry_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: actual id=%0d last=%0b", $time,
                   m_tdata[ID_W-1:0], m_tlast);
        end else begin
          want = expiry_q.pop_front();
          if (m_tdata[ID_W-1:0] !== want.id) begin
            mismatches++;
            $display("%0t: expired_timer_id mismatch: expected %0d, actual %0d", $time,
                     want.id, m_tdata[ID_W-1:0]);
          end
          if (m_tlast !== want.last) begin
            mismatches++;
            $display("%0t: last mismatch: expected %0b, actual %0b", $time,
                     want.last, m_tlast);
          end
        end
        stall = quiet ? 0 : $urandom_range(0, 3);
      end else begin
        stall = (stall_left > 0) ? stall_left - 1 : 0;
      end
      stall_left <= stall;
      m_tready <= (stall == 0) && (hold_left == 0);
    end
  end

  initial begin : stimulus
    timer_req_t r;
    for (int i = 0; i < NUM_TIMERS; i++) armed[i] = 1'b0;

    // Directed part: empty tick, cancel of an idle timer, zero and full-scale
    // durations, zero period, a period of more than half the time range,
    // re-arming an armed timer, then all sixteen timers due on one tick with
    // equal deadlines, which also hits the result cap.
    add_req(OP_TICK, 4'd0, '0, 1'b0);
    add_req(OP_CANCEL, 4'd5, '0, 1'b0);
    add_req(OP_ARM_ONESHOT, 4'd0, 32'd0, 1'b0);
    add_req(OP_ARM_ONESHOT, 4'd15, 32'hFFFF_FFFF, 1'b0);
    add_req(OP_ARM_PERIODIC, 4'd3, 32'd0, 1'b0);
    add_req(OP_ARM_PERIODIC, 4'd9, 32'hC000_0000, 1'b0);
    add_req(OP_ARM_ONESHOT, 4'd0, 32'd2, 1'b0);
    add_req(OP_TICK, 4'd0, '0, 1'b0);
    for (int i = 0; i < NUM_TIMERS; i++)
      add_req((i % 2 == 0) ? OP_ARM_PERIODIC : OP_ARM_ONESHOT, tid_t'(i), 32'd1, i == 0);
    add_req(OP_TICK, 4'd0, '0, 1'b0);

    // Random part, with two points where the driver waits for the queue to drain.
    for (int i = 0; i < 435; i++) begin
      r = random_req();
      r.wait_idle = (i == 120) || (i == 300);
      req_queue.push_back(r);
    end
    total_reqs = req_queue.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (accepted_reqs < total_reqs || expiry_q.size() != 0) @(posedge clk);
    // Let a last tick with up to sixteen pops and re-arms run out.
    repeat (60) @(posedge clk);

    if (mismatches == 0 && expiry_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tdtq_pkg.sv
rtl/tdtq_cell.sv
rtl/tdtq_chain.sv
rtl/sorted_deadline_timer_queue.sv
dv/tb_sorted_deadline_timer_queue.sv
